// File: design/sss_pkg.sv
// Package for the two-digit seven-segment scanner.
// Holds state codes, scan phases, config indexes and reset values, the segment table and the status struct.
// No dependencies; imported by sss_state, sss_encode and the top level.
package sss_pkg;

  // System state codes
  localparam logic [2:0] ST_FAULT     = 3'd0;
  localparam logic [2:0] ST_STOP      = 3'd1;
  localparam logic [2:0] ST_STANDBY   = 3'd2;
  localparam logic [2:0] ST_CHARGE    = 3'd3;
  localparam logic [2:0] ST_DISCHARGE = 3'd4;
  localparam logic [2:0] ST_RUN       = 3'd5;

  // Scan phases
  localparam logic [1:0] PH_ONES   = 2'd0;
  localparam logic [1:0] PH_TENS   = 2'd1;
  localparam logic [1:0] PH_LEDS   = 2'd2;
  localparam logic [1:0] PH_UNUSED = 2'd3;

  // Configuration register indexes
  localparam logic CFG_BLINK_ON     = 1'b0;
  localparam logic CFG_BLINK_PERIOD = 1'b1;

  localparam logic [7:0] BLINK_ON_RST     = 8'd100;
  localparam logic [7:0] BLINK_PERIOD_RST = 8'd200;

  // Largest value shown on two digits
  localparam logic [7:0] MAX_SHOWN = 8'd99;
  // floor(x / 10) == (x * 103) >> 10 for x below 179
  localparam logic [6:0] DIV10_MUL   = 7'd103;
  localparam int         DIV10_SHIFT = 10;

  // Status handed from the state keeper to the encoder
  typedef struct packed {
    logic [1:0] phase;
    logic       blink_lit;
  } status_t;

  // Segment pattern, G..A in bits 6..0
  function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
    logic [6:0] seg;
    case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

// File: design/sss_state.sv
// Scan phase counter and run-LED blink counter.
// Depends on sss_pkg; advances once per transaction moved to the result register.
module sss_state (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic [2:0]           sys_state,
  input  logic [7:0]           blink_on,
  input  logic [7:0]           blink_period,
  output sss_pkg::status_t     status
);
  import sss_pkg::*;

  logic [1:0] scan_phase;
  logic [1:0] scan_phase_next;
  logic [7:0] blink_count;
  logic [7:0] blink_count_next;
  logic [7:0] blink_inc;
  logic       blinking;

  assign blinking  = (sys_state == ST_CHARGE) || (sys_state == ST_DISCHARGE);
  assign blink_inc = blink_count + 8'd1;

  // Current status seen by the encoder for this transaction
  assign status.phase     = scan_phase;
  assign status.blink_lit = (blink_count < blink_on);

  // Next values
  always_comb begin
    blink_count_next = blink_count;
    if (blinking) begin
      blink_count_next = (blink_inc >= blink_period) ? 8'd0 : blink_inc;
    end
    case (scan_phase)
      PH_ONES: scan_phase_next = PH_TENS;
      PH_TENS: scan_phase_next = PH_LEDS;
      default: scan_phase_next = PH_ONES;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase  <= PH_ONES;
      blink_count <= 8'd0;
    end else if (advance) begin
      scan_phase  <= scan_phase_next;
      blink_count <= blink_count_next;
    end
  end

endmodule

// File: design/sss_encode.sv
// Builds the 16-bit shift-register word for one tick.
// Depends on sss_pkg; pure combinational decode of state, value and phase.
module sss_encode (
  input  logic [2:0]           sys_state,
  input  logic [7:0]           count_value,
  input  sss_pkg::status_t     status,
  output logic [15:0]          shift_word
);
  import sss_pkg::*;

  logic [6:0]  val_sat;
  logic [13:0] tens_prod;
  logic [3:0]  tens;
  logic [3:0]  ones;
  logic [6:0]  tens_x10;
  logic        led_fault;
  logic        led_run;
  logic        led_chg;
  logic        led_dis;
  logic [15:0] leds;

  // Saturate to 99 and split into digits
  assign val_sat   = (count_value > MAX_SHOWN) ? MAX_SHOWN[6:0] : count_value[6:0];
  assign tens_prod = val_sat * DIV10_MUL;
  assign tens      = tens_prod[DIV10_SHIFT +: 4];
  assign tens_x10  = {tens, 3'b000} + {2'b00, tens, 1'b0};
  assign ones      = 4'(val_sat - tens_x10);

  // Status LEDs; undefined codes behave like run
  assign led_fault = (sys_state == ST_FAULT);
  assign led_chg   = (sys_state == ST_CHARGE);
  assign led_dis   = (sys_state == ST_DISCHARGE);
  assign led_run   = (led_chg || led_dis) ? status.blink_lit
                   : !(led_fault || (sys_state == ST_STOP));
  assign leds      = {led_fault, led_run, led_chg, led_dis, 12'h000};

  // Phase select; stop blanks everything
  always_comb begin
    shift_word = 16'h0000;
    if (sys_state != ST_STOP) begin
      case (status.phase)
        PH_ONES: shift_word = leds | {4'h0, 1'b0, seg_pattern(ones), 4'b1000};
        PH_TENS: shift_word = leds | {4'h0, 1'b0, seg_pattern(tens), 4'b0100};
        PH_LEDS: shift_word = leds;
        default: shift_word = 16'h0000;
      endcase
    end
  end

endmodule

// File: design/two_digit_seven_segment_scanner_top.sv
// Top level of the two-digit seven-segment scanner.
// Depends on sss_pkg, sss_state and sss_encode.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  tick in | in_valid/in_ready, sys_state,    | input
//          | count_value                      |
//  word out| out_valid/out_ready, shift_word  | output
//  config  | cfg_wr_en, cfg_index, cfg_data   | input
//
// One transaction per cycle unless the output stalls: input register, one decode
// stage, result register; shift_word is decoded from the input register.
// Synchronous active-high reset clears both valid flags, the scan phase, the
// blink counter and restores the blink registers (100 / 200).
// A stalled result holds in the output register; an empty input register takes
// one more transaction, then in_ready stays low until the result is taken.
module two_digit_seven_segment_scanner_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  sys_state,
  input  logic [7:0]  count_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] shift_word,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import sss_pkg::*;

  logic             s1_valid;
  logic [2:0]       s1_state;
  logic [7:0]       s1_value;
  logic             out_free;
  logic             advance;
  logic [7:0]       blink_on;
  logic [7:0]       blink_period;
  status_t          status;
  logic [15:0]      word_next;

  // Handshake
  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && out_free;
  assign in_ready = !s1_valid || advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      blink_on     <= BLINK_ON_RST;
      blink_period <= BLINK_PERIOD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BLINK_ON:     blink_on     <= cfg_data;
        CFG_BLINK_PERIOD: blink_period <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_state <= sys_state;
      s1_value <= count_value;
    end
  end

  sss_state u_state (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .sys_state    (s1_state),
    .blink_on     (blink_on),
    .blink_period (blink_period),
    .status       (status)
  );

  sss_encode u_encode (
    .sys_state   (s1_state),
    .count_value (s1_value),
    .status      (status),
    .shift_word  (word_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      shift_word <= word_next;
    end
  end

  // Checks
  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    status.phase != PH_UNUSED)
    else $error("scan phase reached unused code");

  a_stop_blank: assert property (@(posedge clk) disable iff (rst)
    (advance && (s1_state == ST_STOP)) |=> (shift_word == 16'h0000))
    else $error("stop state produced a non-blank word");

  a_one_select: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(shift_word[3] && shift_word[2]))
    else $error("both digit selects driven");

  a_low_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (shift_word[1:0] == 2'b00) && !shift_word[11])
    else $error("unused word bits set");

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for two_digit_seven_segment_scanner_top: directed and
// random scan ticks through valid/ready, with a scoreboard against a behavioural
// scanner model. Depends on sss_pkg and the scanner RTL.
module tb;
  import sss_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int BLOCK_TICKS = 300;
  localparam int SETTLE_CYCLES = 4;
  // Segment patterns G..A, digit 0 in the low seven bits
  localparam logic [69:0] DIGIT_SEGS = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                        7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

  typedef struct packed {
    logic [2:0] st;
    logic [7:0] cnt;
  } tick_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  sys_state = ST_FAULT;
  logic [7:0]  count_value = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] shift_word;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = CFG_BLINK_ON;
  logic [7:0]  cfg_data = 8'd0;

  tick_t       pending_ticks[$];
  logic [15:0] expected_words[$];
  int          send_idle_pct = 11;
  int          recv_stall_pct = 80;
  bit          hold_send = 1'b0;
  int          err_count = 0;
  int          cycle_count = 0;
  // transactions taken off the pending queue whose word has not yet been checked
  int          in_flight = 0;

  // Scanner model state and register copies
  logic [1:0]  model_phase = PH_ONES;
  logic [7:0]  model_blink = 8'd0;
  logic [7:0]  model_on = BLINK_ON_RST;
  logic [7:0]  model_period = BLINK_PERIOD_RST;

  two_digit_seven_segment_scanner_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .sys_state(sys_state), .count_value(count_value),
    .out_valid(out_valid), .out_ready(out_ready), .shift_word(shift_word),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Advance the model by one tick and return the word it should shift out
  task automatic scan_tick(input tick_t t, output logic [15:0] word);
    int         shown;
    int         ones_i;
    int         tens_i;
    logic       f, r, c, d;
    logic [3:0] leds;
    shown = (t.cnt > MAX_SHOWN) ? MAX_SHOWN : t.cnt;
    ones_i = shown % 10;
    tens_i = shown / 10;
    f = 1'b0; r = 1'b0; c = 1'b0; d = 1'b0;
    case (t.st)
      ST_FAULT:     f = 1'b1;
      ST_STOP:      ;
      ST_CHARGE:    c = 1'b1;
      ST_DISCHARGE: d = 1'b1;
      default:      r = 1'b1; // standby, run and the undefined codes
    endcase
    // run LED blinks only while charging or discharging
    if (t.st == ST_CHARGE || t.st == ST_DISCHARGE) begin
      r = (model_blink < model_on);
      model_blink = model_blink + 8'd1;
      if (model_blink >= model_period) model_blink = 8'd0;
    end
    leds = {f, r, c, d};
    if (t.st == ST_STOP) begin
      word = 16'h0000;
    end else begin
      case (model_phase)
        PH_ONES: word = {leds, 1'b0, DIGIT_SEGS[ones_i*7 +: 7], 4'b1000};
        PH_TENS: word = {leds, 1'b0, DIGIT_SEGS[tens_i*7 +: 7], 4'b0100};
        PH_LEDS: word = {leds, 12'h000};
        default: word = 16'h0000;
      endcase
    end
    model_phase = (model_phase == PH_LEDS || model_phase == PH_UNUSED) ?
                  PH_ONES : model_phase + 2'd1;
  endtask

  // Input driver: records each accepted transaction in the model
  always @(posedge clk) begin
    tick_t       t;
    logic [15:0] w;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        t.st = sys_state;
        t.cnt = count_value;
        scan_tick(t, w);
        expected_words.push_back(w);
      end
      if (!in_valid || in_ready) begin
        if (pending_ticks.size() != 0 && !hold_send &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          t = pending_ticks.pop_front();
          in_flight++;
          in_valid <= 1'b1;
          sys_state <= t.st;
          count_value <= t.cnt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor and scoreboard
  always @(posedge clk) begin
    logic [15:0] want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        in_flight--;
        if (expected_words.size() == 0) begin
          err_count++;
          $display("%0t: unexpected shift_word %h", $time, shift_word);
        end else begin
          want = expected_words.pop_front();
          if (shift_word !== want) begin
            err_count++;
            $display("%0t: shift_word mismatch, expected %h actual %h",
                     $time, want, shift_word);
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("two_digit_seven_segment_scanner_top regression: fail");
      $finish;
    end
  end

  // Register write; only called with the block idle
  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_BLINK_ON) model_on = val;
    else model_period = val;
  endtask

  // Wait until every queued tick is through and its word has come out
  task automatic drain();
    while (pending_ticks.size() != 0 || in_flight != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic tick_t random_tick();
    tick_t t;
    int    pick;
    pick = $urandom_range(0, 99);
    // bias towards charge/discharge so the blink counter wraps often
    if (pick < 55) t.st = ($urandom_range(0, 1) != 0) ? ST_CHARGE : ST_DISCHARGE;
    else t.st = 3'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      t.cnt = 8'($urandom_range(0, 99));
    end else if (pick < 45) begin
      case ($urandom_range(0, 3))
        0:       t.cnt = 8'd0;
        1:       t.cnt = 8'd99;
        2:       t.cnt = 8'd100;
        default: t.cnt = 8'd255;
      endcase
    end else begin
      t.cnt = 8'($urandom_range(0, 255));
    end
    return t;
  endfunction

  initial begin
    tick_t      t;
    logic [7:0] on_v;
    logic [7:0] per_v;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: every state code, including the undefined ones, at the count extremes
    for (int s = 0; s < 8; s++) begin
      for (int k = 0; k < 3; k++) begin
        t.st = 3'(s);
        t.cnt = (k == 0) ? 8'd0 : (k == 1) ? 8'd99 : 8'd255;
        pending_ticks.push_back(t);
      end
    end
    drain();

    // Random blocks, each under its own blink settings
    for (int blk = 0; blk < 6; blk++) begin
      case (blk)
        0: begin on_v = 8'd3;   per_v = 8'd7;   end
        1: begin on_v = 8'd0;   per_v = 8'd0;   end
        2: begin on_v = 8'd255; per_v = 8'd255; end
        3: begin on_v = 8'd1;   per_v = 8'd1;   end
        4: begin
          on_v = 8'($urandom_range(0, 20));
          per_v = 8'($urandom_range(1, 20));
        end
        default: begin
          on_v = 8'($urandom_range(0, 255));
          per_v = 8'($urandom_range(0, 255));
        end
      endcase
      if (blk == 2) begin
        send_idle_pct = 80;
        recv_stall_pct = 11;
      end else if (blk == 4) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      write_reg(CFG_BLINK_ON, on_v);
      write_reg(CFG_BLINK_PERIOD, per_v);
      for (int i = 0; i < BLOCK_TICKS; i++) begin
        // hold the sender until the output side has fully emptied
        if (blk == 3 && i == BLOCK_TICKS / 2) begin
          while (pending_ticks.size() != 0) @(posedge clk);
          hold_send = 1'b1;
          drain();
          hold_send = 1'b0;
        end
        pending_ticks.push_back(random_tick());
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("two_digit_seven_segment_scanner_top regression: pass");
    end else begin
      $display("two_digit_seven_segment_scanner_top regression: fail");
    end
    $finish;
  end

endmodule

// File: two_digit_seven_segment_scanner_top.f
design/sss_pkg.sv
design/sss_state.sv
design/sss_encode.sv
design/two_digit_seven_segment_scanner_top.sv
verif/tb.sv
